>>> sv/mks_pkg.sv
// shared types, constants and the key code lookup for the keypad scanner
// no dependencies
package mks_pkg;

    localparam int unsigned PinW   = 8;
    localparam int unsigned NibW   = 4;
    localparam int unsigned TickW  = 10;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned KeyN   = 16;

    localparam logic [CfgIdxW-1:0] REG_SETTLE   = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_DEBOUNCE = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_POLL     = 2'd2;

    localparam logic [TickW-1:0] SETTLE_RESET   = 10'd20;
    localparam logic [TickW-1:0] DEBOUNCE_RESET = 10'd20;
    localparam logic [TickW-1:0] POLL_RESET     = 10'd10;

    localparam logic [NibW-1:0] NIB_ALL_HIGH = 4'hf;

    localparam logic [PinW-1:0] KEY_CODES [KeyN] = '{
        8'hde, 8'hb7, 8'hd7, 8'he7, 8'hbb, 8'hdb, 8'heb, 8'hbd,
        8'hdd, 8'hed, 8'hbe, 8'h77, 8'h7b, 8'h7d, 8'h7e, 8'hee
    };

    typedef struct packed {
        logic [TickW-1:0] settle_ticks;
        logic [TickW-1:0] debounce_ticks;
        logic [TickW-1:0] poll_ticks;
    } cfg_t;

    typedef struct packed {
        logic            unmatched;
        logic [NibW-1:0] index;
    } key_t;

    typedef struct packed {
        logic            drive_low_nibble;
        logic            key_valid;
        logic [NibW-1:0] key_index;
        logic            key_unmatched;
    } result_t;

    // highest matching position wins
    function automatic key_t decode_key(input logic [PinW-1:0] pattern);
        key_t k;
        k.unmatched = 1'b1;
        k.index     = '0;
        for (int i = 0; i < KeyN; i++) begin
            if (pattern == KEY_CODES[i]) begin
                k.unmatched = 1'b0;
                k.index     = NibW'(i);
            end
        end
        return k;
    endfunction

endpackage

>>> sv/mks_ifs.sv
// valid/ready channel interfaces for pin ticks, results and register writes
// depends on mks_pkg
interface mks_in_if;
    import mks_pkg::*;
    logic            valid;
    logic            ready;
    logic [PinW-1:0] pins_in;
    modport source (output valid, output pins_in, input ready);
    modport sink   (input valid, input pins_in, output ready);
endinterface

interface mks_out_if;
    import mks_pkg::*;
    logic            valid;
    logic            ready;
    logic            drive_low_nibble;
    logic            key_valid;
    logic [NibW-1:0] key_index;
    logic            key_unmatched;
    modport source (output valid, output drive_low_nibble, output key_valid,
                    output key_index, output key_unmatched, input ready);
    modport sink   (input valid, input drive_low_nibble, input key_valid,
                    input key_index, input key_unmatched, output ready);
endinterface

interface mks_cfg_if;
    import mks_pkg::*;
    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [TickW-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/matrix_keypad_scanner.sv
// 4x4 line-reversal keypad scanner, one pin-level tick per transfer.
// a tick's result is captured into the output register on its transfer.
// throughput: one tick per cycle while the output side is ready; the scan sequencer updates once per transfer
// and the output register refills in the cycle it is emptied.
// reset: registers to 20/20/10, scan restarts in forward settle, no result held.
// depends on mks_pkg, mks_ifs, mks_cfg_regs, mks_scan_core
module matrix_keypad_scanner (
    input  logic      clk,
    input  logic      rst_n,
    mks_in_if.sink    in_ch,
    mks_out_if.source out_ch,
    mks_cfg_if.sink   cfg_ch
);
    import mks_pkg::*;

    cfg_t    cfg;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    step;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign step         = in_ch.valid && in_ch.ready;

    mks_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_ch.valid),
        .wr_index (cfg_ch.index),
        .wr_data  (cfg_ch.data),
        .cfg      (cfg)
    );

    mks_scan_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .pins   (in_ch.pins_in),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ch.ready)
            out_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_reg <= result;
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.drive_low_nibble = out_reg.drive_low_nibble;
    assign out_ch.key_valid        = out_reg.key_valid;
    assign out_ch.key_index        = out_reg.key_index;
    assign out_ch.key_unmatched    = out_reg.key_unmatched;

endmodule

>>> sv/mks_cfg_regs.sv
// timing registers for the scanner, written through the config channel
// depends on mks_pkg
module mks_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [mks_pkg::CfgIdxW-1:0] wr_index,
    input  logic [mks_pkg::TickW-1:0]   wr_data,
    output mks_pkg::cfg_t               cfg
);
    import mks_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_ticks   <= SETTLE_RESET;
            cfg_reg.debounce_ticks <= DEBOUNCE_RESET;
            cfg_reg.poll_ticks     <= POLL_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_SETTLE:   cfg_reg.settle_ticks   <= wr_data;
                REG_DEBOUNCE: cfg_reg.debounce_ticks <= wr_data;
                REG_POLL:     cfg_reg.poll_ticks     <= wr_data;
                default:      ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/mks_scan_core.sv
// line-reversal scan sequencer: phase, tick counter, captured nibble, decoded key
// depends on mks_pkg
module mks_scan_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [mks_pkg::PinW-1:0] pins,
    input  mks_pkg::cfg_t            cfg,
    output mks_pkg::result_t         result
);
    import mks_pkg::*;

    localparam logic [2:0] PH_SETTLE_FWD = 3'd0;
    localparam logic [2:0] PH_POLL       = 3'd1;
    localparam logic [2:0] PH_DEBOUNCE   = 3'd2;
    localparam logic [2:0] PH_SETTLE_REV = 3'd3;
    localparam logic [2:0] PH_RELEASE    = 3'd4;

    logic [2:0]       phase_reg, phase_next;
    logic [TickW-1:0] count_reg, count_next;
    logic [NibW-1:0]  cap_reg, cap_next;
    key_t             key_reg, key_next;
    logic             valid_now;
    logic             do_poll;
    logic [NibW-1:0]  hi, lo;

    assign hi = pins[PinW-1:NibW];
    assign lo = pins[NibW-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        cap_next   = cap_reg;
        key_next   = key_reg;
        valid_now  = 1'b0;
        do_poll    = 1'b0;

        unique case (phase_reg)
            PH_SETTLE_FWD:
            begin
                if (count_reg < cfg.settle_ticks)
                    count_next = count_reg + 1'b1;
                else
                begin
                    phase_next = PH_POLL;
                    do_poll    = 1'b1;
                end
            end
            PH_POLL:
            begin
                if (count_reg != '0 && count_reg < cfg.poll_ticks)
                    count_next = count_reg + 1'b1;
                else
                    do_poll = 1'b1;
            end
            PH_DEBOUNCE:
            begin
                if (count_reg < cfg.debounce_ticks)
                    count_next = count_reg + 1'b1;
                else if (hi == cap_reg)
                begin
                    phase_next = PH_SETTLE_REV;
                    count_next = '0;
                end
                else
                begin
                    // failed confirm: poll again on this same tick
                    phase_next = PH_POLL;
                    do_poll    = 1'b1;
                end
            end
            PH_SETTLE_REV:
            begin
                if (count_reg < cfg.settle_ticks)
                    count_next = count_reg + 1'b1;
                else
                begin
                    key_next   = decode_key({cap_reg, lo});
                    phase_next = PH_RELEASE;
                    count_next = '0;
                end
            end
            PH_RELEASE:
            begin
                if (hi == NIB_ALL_HIGH)
                begin
                    valid_now  = 1'b1;
                    phase_next = PH_SETTLE_FWD;
                    count_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_SETTLE_FWD;
                count_next = '0;
            end
        endcase

        if (do_poll)
        begin
            if (hi == NIB_ALL_HIGH)
                count_next = TickW'(1);
            else
            begin
                cap_next   = hi;
                phase_next = PH_DEBOUNCE;
                count_next = '0;
            end
        end
    end

    always_comb
    begin
        result.drive_low_nibble = (phase_reg != PH_SETTLE_REV);
        result.key_valid        = valid_now;
        result.key_index        = (valid_now && !key_reg.unmatched) ? key_reg.index : '0;
        result.key_unmatched    = valid_now && key_reg.unmatched;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SETTLE_FWD;
            count_reg <= '0;
            cap_reg   <= NIB_ALL_HIGH;
            key_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
            key_reg   <= key_next;
        end
    end

endmodule
